### design/vpa_pkg.sv
// Shared types and constants for the variable partition allocator.
package vpa_pkg;

   localparam int SEG_SLOTS_DEF = 16;
   localparam int ADDR_BITS_DEF = 16;
   localparam int OWNER_W       = 7;
   localparam int FIELD_W       = 16;

   // CSR byte address of the fit_mode register
   localparam logic [1:0] CSR_FIT_MODE_ADDR = 2'd0;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_HOLES   = 3'd1;
   localparam logic [2:0] ST_NO_FIT     = 3'd2;
   localparam logic [2:0] ST_NO_ALLOC   = 3'd3;
   localparam logic [2:0] ST_NO_OWNER   = 3'd4;
   localparam logic [2:0] ST_TABLE_FULL = 3'd5;
   localparam logic [2:0] ST_BAD_PART   = 3'd6;

   typedef enum logic [1:0] {
      CMD_LOAD     = 2'd0,
      CMD_ALLOC    = 2'd1,
      CMD_RELEASE  = 2'd2,
      CMD_COALESCE = 2'd3
   } command_type;

   // per-entry verdicts from the evaluation unit
   typedef struct packed {
      logic overlap;
      logic below;
      logic fits;
      logic better;
      logic owner_match;
      logic touch;
   } fit_flags_type;

endpackage

### design/vpa_seg_mem.sv
// Segment table storage: one write port, one registered read port.
module vpa_seg_mem import vpa_pkg::*; #(
   parameter int DEPTH = SEG_SLOTS_DEF,
   parameter int WIDTH = 2 * ADDR_BITS_DEF + OWNER_W + 1,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/vpa_fit_unit.sv
// Shared evaluation unit: judges one table entry against the current request.
module vpa_fit_unit import vpa_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic [ADDR_BITS-1:0] ent_beg,
   input  logic [ADDR_BITS-1:0] ent_fin,
   input  logic [OWNER_W-1:0]   ent_own,
   input  logic                 ent_hole,
   input  logic [ADDR_BITS-1:0] size,
   input  logic [ADDR_BITS-1:0] part_start,
   input  logic [ADDR_BITS-1:0] part_end,
   input  logic [OWNER_W-1:0]   pid,
   input  logic [ADDR_BITS-1:0] best,
   input  logic                 found,
   input  logic [1:0]           fit_mode,
   input  logic [ADDR_BITS-1:0] cur_fin,
   input  logic                 cur_hole,
   output fit_flags_type        flags,
   output logic [ADDR_BITS-1:0] rem
);

   logic [ADDR_BITS-1:0] len;

   always_comb begin
      len = ent_fin - ent_beg;
      rem = len - size;
      flags.overlap     = (part_start < ent_fin) && (ent_beg < part_end);
      flags.below       = ent_beg < part_start;
      flags.fits        = !(len < size);
      flags.owner_match = ent_own == pid;
      flags.touch       = cur_hole && ent_hole && (cur_fin == ent_beg);
      if (!found) begin
         flags.better = 1'b1;
      end else begin
         unique case (fit_mode)
            FIT_BEST:  flags.better = rem < best;
            FIT_WORST: flags.better = rem > best;
            default:   flags.better = 1'b0;
         endcase
      end
   end

endmodule

### design/variable_partition_allocator_top.sv
// Variable partition allocator: top level with command sequencer and ports.
// Keeps up to SEG_SLOTS segments sorted by start address in a table with one
// write port and one registered read port, and serves one request at a time;
// req_tready is high only while idle. Each table visit sets the address, then
// takes the registered data, all through one shared evaluation unit. A load or
// a split that opens a slot moves the entries above it up one by one, and
// coalesce does one compacting pass over the table.
// A finished response waits in the output register while the next request
// is accepted. fit_mode at CSR byte address 0 selects first, best or worst
// fit (code 3 acts as first fit); write it only while the block is idle.
module variable_partition_allocator_top import vpa_pkg::*; #(
   parameter int SEG_SLOTS = SEG_SLOTS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] process_id, [22:7] request_size, [38:23] part_start,
   // [54:39] part_end, [55] pad
   input  logic [55:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [18:3] block_start, [34:19] block_end, [39:35] zero
   output logic [39:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(SEG_SLOTS);
   localparam int CNT_W = $clog2(SEG_SLOTS + 1);
   localparam int ENT_W = 2 * ADDR_BITS + OWNER_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_SH_RD, S_SH_WR,
      S_PUT, S_PUT2, S_CO_LOAD, S_CO_RD, S_CO_EV, S_CO_END, S_DONE
   } state_type;

   state_type            state_ff;
   command_type          cmd_ff;
   logic [OWNER_W-1:0]   pid_ff;
   logic [ADDR_BITS-1:0] size_ff, ps_ff, pe_ff;
   logic [1:0]           fit_mode_ff;
   logic [CNT_W-1:0]     count_ff, idx_ff, pos_ff, pick_ff, wr_ff;
   logic                 pos_set_ff, found_ff, any_ff, bad_ff;
   logic [ADDR_BITS-1:0] best_ff, pbeg_ff, pfin_ff;
   logic [ADDR_BITS-1:0] cbeg_ff, cfin_ff;
   logic [OWNER_W-1:0]   cown_ff;
   logic                 chole_ff;
   logic [2:0]           res_st_ff, rsp_st_ff;
   logic [ADDR_BITS-1:0] res_bs_ff, res_be_ff, rsp_bs_ff, rsp_be_ff;
   logic                 rsp_valid_ff;

   // table entry: {hole, owner, finish, begin}
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr, mem_raddr;
   logic [ENT_W-1:0]     mem_wdata, mem_rdata;
   logic [ADDR_BITS-1:0] e_beg, e_fin;
   logic [OWNER_W-1:0]   e_own;
   logic                 e_hole;

   fit_flags_type        flags;
   logic [ADDR_BITS-1:0] rem;
   logic [ADDR_BITS-1:0] split_at;
   logic                 table_full, last_idx;
   logic                 alloc_exact, release_ok;

   assign {e_hole, e_own, e_fin, e_beg} = mem_rdata;
   assign split_at   = pbeg_ff + size_ff;
   assign table_full = count_ff == CNT_W'(SEG_SLOTS);
   assign last_idx   = (idx_ff + CNT_W'(1)) == count_ff;
   assign alloc_exact = any_ff && (size_ff != '0) && found_ff && (best_ff == '0);
   assign release_ok  = any_ff && found_ff;

   vpa_seg_mem #(.DEPTH(SEG_SLOTS), .WIDTH(ENT_W)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   vpa_fit_unit #(.ADDR_BITS(ADDR_BITS)) u_fit (
      .ent_beg    (e_beg),
      .ent_fin    (e_fin),
      .ent_own    (e_own),
      .ent_hole   (e_hole),
      .size       (size_ff),
      .part_start (ps_ff),
      .part_end   (pe_ff),
      .pid        (pid_ff),
      .best       (best_ff),
      .found      (found_ff),
      .fit_mode   (fit_mode_ff),
      .cur_fin    (cfin_ff),
      .cur_hole   (chole_ff),
      .flags      (flags),
      .rem        (rem)
   );

   // table port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = mem_rdata;
      mem_raddr = idx_ff[IDX_W-1:0];
      unique case (state_ff)
         S_START: begin
            mem_raddr = '0;
         end
         S_SH_RD: begin
            mem_raddr = IDX_W'(idx_ff - CNT_W'(1));
         end
         S_SH_WR: begin
            mem_we = 1'b1;
         end
         S_DECIDE: begin
            mem_waddr = pick_ff[IDX_W-1:0];
            if (cmd_ff == CMD_ALLOC && alloc_exact) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b0, pid_ff, pfin_ff, pbeg_ff};
            end else if (cmd_ff == CMD_RELEASE && release_ok) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, OWNER_W'(0), pfin_ff, pbeg_ff};
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[IDX_W-1:0];
            if (cmd_ff == CMD_LOAD) begin
               mem_wdata = {1'b1, OWNER_W'(0), pe_ff, ps_ff};
            end else begin
               mem_wdata = {1'b1, OWNER_W'(0), pfin_ff, split_at};
            end
         end
         S_PUT2: begin
            mem_we    = 1'b1;
            mem_waddr = pick_ff[IDX_W-1:0];
            mem_wdata = {1'b0, pid_ff, split_at, pbeg_ff};
         end
         S_CO_EV: begin
            mem_we    = !flags.touch;
            mem_waddr = wr_ff[IDX_W-1:0];
            mem_wdata = {chole_ff, cown_ff, cfin_ff, cbeg_ff};
         end
         S_CO_END: begin
            mem_we    = 1'b1;
            mem_waddr = wr_ff[IDX_W-1:0];
            mem_wdata = {chole_ff, cown_ff, cfin_ff, cbeg_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fit_mode_ff  <= FIT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_FIT_MODE_ADDR) begin
            fit_mode_ff <= csr_pwdata[1:0];
         end
         // S_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= command_type'(req_tuser);
                  pid_ff   <= req_tdata[6:0];
                  size_ff  <= ADDR_BITS'(req_tdata[22:7]);
                  ps_ff    <= ADDR_BITS'(req_tdata[38:23]);
                  pe_ff    <= ADDR_BITS'(req_tdata[54:39]);
                  state_ff <= S_START;
               end
            end
            S_START: begin
               idx_ff     <= '0;
               pos_ff     <= count_ff;
               pos_set_ff <= 1'b0;
               found_ff   <= 1'b0;
               any_ff     <= 1'b0;
               bad_ff     <= 1'b0;
               best_ff    <= '0;
               res_st_ff  <= ST_OK;
               res_bs_ff  <= '0;
               res_be_ff  <= '0;
               unique case (cmd_ff)
                  CMD_LOAD: begin
                     if (!(ps_ff < pe_ff)) begin
                        res_st_ff <= ST_BAD_PART;
                        state_ff  <= S_DONE;
                     end else begin
                        state_ff <= (count_ff == '0) ? S_DECIDE : S_SCAN_RD;
                     end
                  end
                  CMD_ALLOC, CMD_RELEASE: begin
                     state_ff <= (count_ff == '0) ? S_DECIDE : S_SCAN_RD;
                  end
                  CMD_COALESCE: begin
                     // entry 0 is being read this cycle
                     state_ff <= (count_ff > CNT_W'(1)) ? S_CO_LOAD : S_DONE;
                  end
               endcase
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_EV;
            end
            S_SCAN_EV: begin
               unique case (cmd_ff)
                  CMD_LOAD: begin
                     if (flags.overlap) bad_ff <= 1'b1;
                     if (!pos_set_ff && !flags.below) begin
                        pos_ff     <= idx_ff;
                        pos_set_ff <= 1'b1;
                     end
                  end
                  CMD_ALLOC: begin
                     if (e_hole) any_ff <= 1'b1;
                     if (e_hole && flags.fits && flags.better) begin
                        found_ff <= 1'b1;
                        pick_ff  <= idx_ff;
                        best_ff  <= rem;
                        pbeg_ff  <= e_beg;
                        pfin_ff  <= e_fin;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!e_hole) any_ff <= 1'b1;
                     if (!e_hole && flags.owner_match && !found_ff) begin
                        found_ff <= 1'b1;
                        pick_ff  <= idx_ff;
                        pbeg_ff  <= e_beg;
                        pfin_ff  <= e_fin;
                     end
                  end
                  default: begin
                  end
               endcase
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= last_idx ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE: begin
               state_ff <= S_DONE;
               idx_ff   <= count_ff;
               unique case (cmd_ff)
                  CMD_LOAD: begin
                     if (bad_ff) begin
                        res_st_ff <= ST_BAD_PART;
                     end else if (table_full) begin
                        res_st_ff <= ST_TABLE_FULL;
                     end else begin
                        state_ff <= S_SH_RD;
                     end
                  end
                  CMD_ALLOC: begin
                     if (!any_ff) begin
                        res_st_ff <= ST_NO_HOLES;
                     end else if (size_ff == '0 || !found_ff) begin
                        res_st_ff <= ST_NO_FIT;
                     end else if (alloc_exact) begin
                        res_bs_ff <= pbeg_ff;
                        res_be_ff <= pfin_ff;
                     end else if (table_full) begin
                        res_st_ff <= ST_TABLE_FULL;
                     end else begin
                        // remainder stays a hole just above the block
                        pos_ff   <= pick_ff + CNT_W'(1);
                        state_ff <= S_SH_RD;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!any_ff) begin
                        res_st_ff <= ST_NO_ALLOC;
                     end else if (!found_ff) begin
                        res_st_ff <= ST_NO_OWNER;
                     end else begin
                        res_bs_ff <= pbeg_ff;
                        res_be_ff <= pfin_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // open a slot at pos: move entries up from the top down
            S_SH_RD: begin
               state_ff <= (idx_ff == pos_ff) ? S_PUT : S_SH_WR;
            end
            S_SH_WR: begin
               idx_ff   <= idx_ff - CNT_W'(1);
               state_ff <= S_SH_RD;
            end
            S_PUT: begin
               if (cmd_ff == CMD_LOAD) begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_PUT2;
               end
            end
            S_PUT2: begin
               count_ff  <= count_ff + CNT_W'(1);
               res_bs_ff <= pbeg_ff;
               res_be_ff <= split_at;
               state_ff  <= S_DONE;
            end
            // coalesce: one compacting pass, current run held in cur
            S_CO_LOAD: begin
               cbeg_ff  <= e_beg;
               cfin_ff  <= e_fin;
               cown_ff  <= e_own;
               chole_ff <= e_hole;
               idx_ff   <= CNT_W'(1);
               wr_ff    <= '0;
               state_ff <= S_CO_RD;
            end
            S_CO_RD: begin
               state_ff <= S_CO_EV;
            end
            S_CO_EV: begin
               if (flags.touch) begin
                  cfin_ff <= e_fin;
               end else begin
                  cbeg_ff  <= e_beg;
                  cfin_ff  <= e_fin;
                  cown_ff  <= e_own;
                  chole_ff <= e_hole;
                  wr_ff    <= wr_ff + CNT_W'(1);
               end
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= last_idx ? S_CO_END : S_CO_RD;
            end
            S_CO_END: begin
               count_ff <= wr_ff + CNT_W'(1);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_st_ff    <= res_st_ff;
                  rsp_bs_ff    <= res_bs_ff;
                  rsp_be_ff    <= res_be_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, FIELD_W'(rsp_be_ff), FIELD_W'(rsp_bs_ff), rsp_st_ff};

   assign csr_prdata = {30'd0, fit_mode_ff};
   assign csr_pready = 1'b1;

endmodule

### verif/variable_partition_allocator_top_tb.sv
// Self-checking testbench for the variable partition allocator top level.
`timescale 1ns / 100ps

module variable_partition_allocator_top_tb;
   import vpa_pkg::*;

   localparam int SLOTS          = 16;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int DRAIN_CYCLES   = 80;   // extra wait after draining: full-table scan plus shifting, n = 16
   localparam logic [1:0] FIT_SPARE     = 2'd3;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] block_start;
      logic [15:0] block_end;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the segment table
   logic [15:0] shadow_begin [SLOTS];
   logic [15:0] shadow_finish [SLOTS];
   logic [6:0]  shadow_owner [SLOTS];
   logic        shadow_hole [SLOTS];
   int          shadow_count = 0;
   logic [1:0]  shadow_fit = FIT_FIRST;

   alloc_result_type expected_results [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;

   variable_partition_allocator_top uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stalls: three random modes (always ready, coin flip, long stalls)
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (cycle_count % 150 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
            end
         end
      endcase
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", rsp_tdata));
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[2:0] !== exp_r.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tdata[2:0], exp_r.status));
            if (rsp_tdata[18:3] !== exp_r.block_start)
               report_mismatch($sformatf("block_start %0d, expected %0d",
                                         rsp_tdata[18:3], exp_r.block_start));
            if (rsp_tdata[34:19] !== exp_r.block_end)
               report_mismatch($sformatf("block_end %0d, expected %0d",
                                         rsp_tdata[34:19], exp_r.block_end));
         end
      end
   end

   // open a slot at pos by moving entries up
   function void shift_up(input int pos);
      for (int k = shadow_count; k > pos; k--) begin
         shadow_begin[k]  = shadow_begin[k-1];
         shadow_finish[k] = shadow_finish[k-1];
         shadow_owner[k]  = shadow_owner[k-1];
         shadow_hole[k]   = shadow_hole[k-1];
      end
      shadow_count++;
   endfunction

   function alloc_result_type predict_allocator(input command_type cmd, input logic [6:0] pid,
                                                input logic [15:0] size, input logic [15:0] ps,
                                                input logic [15:0] pe);
      alloc_result_type r;
      int pos, pick;
      logic any, found;
      logic [15:0] len, rem, best;
      r.status = ST_OK;
      r.block_start = '0;
      r.block_end = '0;
      pick = 0;
      best = '0;
      any = 1'b0;
      found = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            if (pe <= ps) begin
               r.status = ST_BAD_PART;
               return r;
            end
            for (int i = 0; i < shadow_count; i++)
               if (ps < shadow_finish[i] && shadow_begin[i] < pe) begin
                  r.status = ST_BAD_PART;
                  return r;
               end
            if (shadow_count >= SLOTS) begin
               r.status = ST_TABLE_FULL;
               return r;
            end
            pos = 0;
            while (pos < shadow_count && shadow_begin[pos] < ps) pos++;
            shift_up(pos);
            shadow_begin[pos]  = ps;
            shadow_finish[pos] = pe;
            shadow_owner[pos]  = '0;
            shadow_hole[pos]   = 1'b1;
         end
         CMD_ALLOC: begin
            for (int i = 0; i < shadow_count; i++) if (shadow_hole[i]) any = 1'b1;
            if (!any) begin
               r.status = ST_NO_HOLES;
               return r;
            end
            if (size == 0) begin
               r.status = ST_NO_FIT;
               return r;
            end
            for (int i = 0; i < shadow_count; i++) begin
               if (!shadow_hole[i]) continue;
               len = shadow_finish[i] - shadow_begin[i];
               if (len < size) continue;
               rem = len - size;
               if (!found) begin
                  found = 1'b1;
                  pick = i;
                  best = rem;
                  if (shadow_fit != FIT_BEST && shadow_fit != FIT_WORST) break;
               end else if ((shadow_fit == FIT_BEST && rem < best) ||
                            (shadow_fit == FIT_WORST && rem > best)) begin
                  pick = i;
                  best = rem;
               end
            end
            if (!found) begin
               r.status = ST_NO_FIT;
               return r;
            end
            if (best > 0) begin
               if (shadow_count >= SLOTS) begin
                  r.status = ST_TABLE_FULL;
                  return r;
               end
               shift_up(pick + 1);
               shadow_begin[pick+1]  = shadow_begin[pick] + size;
               shadow_finish[pick+1] = shadow_finish[pick];
               shadow_owner[pick+1]  = '0;
               shadow_hole[pick+1]   = 1'b1;
               shadow_finish[pick]   = shadow_begin[pick] + size;
            end
            shadow_owner[pick] = pid;
            shadow_hole[pick]  = 1'b0;
            r.block_start = shadow_begin[pick];
            r.block_end   = shadow_finish[pick];
         end
         CMD_RELEASE: begin
            for (int i = 0; i < shadow_count; i++) if (!shadow_hole[i]) any = 1'b1;
            if (!any) begin
               r.status = ST_NO_ALLOC;
               return r;
            end
            for (int i = 0; i < shadow_count; i++)
               if (!shadow_hole[i] && shadow_owner[i] == pid) begin
                  shadow_hole[i]  = 1'b1;
                  shadow_owner[i] = '0;
                  r.block_start = shadow_begin[i];
                  r.block_end   = shadow_finish[i];
                  return r;
               end
            r.status = ST_NO_OWNER;
         end
         default: begin
            pos = 0;
            while (pos + 1 < shadow_count) begin
               if (shadow_hole[pos] && shadow_hole[pos+1] &&
                   shadow_finish[pos] == shadow_begin[pos+1]) begin
                  shadow_finish[pos] = shadow_finish[pos+1];
                  for (int k = pos + 1; k < shadow_count - 1; k++) begin
                     shadow_begin[k]  = shadow_begin[k+1];
                     shadow_finish[k] = shadow_finish[k+1];
                     shadow_owner[k]  = shadow_owner[k+1];
                     shadow_hole[k]   = shadow_hole[k+1];
                  end
                  shadow_count--;
               end else begin
                  pos++;
               end
            end
         end
      endcase
      return r;
   endfunction

   // one request; the sender runs in bursts with random gaps between them
   task automatic send_request(input command_type cmd, input logic [6:0] pid,
                               input logic [15:0] size, input logic [15:0] ps,
                               input logic [15:0] pe);
      if (burst_left == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, pe, ps, size, pid};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_allocator(cmd, pid, size, ps, pe));
   endtask

   // hold off until every outstanding response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_fit_mode(input logic [1:0] mode);
      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_FIT_MODE_ADDR;
      csr_pwdata  <= {30'd0, mode};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow_fit = mode;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_empty_table();
      send_request(CMD_ALLOC, 7'd5, 16'd10, '0, '0);       // no holes
      send_request(CMD_RELEASE, 7'd5, '0, '0, '0);          // nothing allocated
      send_request(CMD_COALESCE, '0, '0, '0, '0);           // ok on empty table
   endtask

   task automatic test_load_checks();
      send_request(CMD_LOAD, '0, '0, 16'd100, 16'd100);     // empty partition
      send_request(CMD_LOAD, '0, '0, 16'd200, 16'd100);     // inverted
      send_request(CMD_LOAD, '0, '0, 16'd0, 16'd100);
      send_request(CMD_LOAD, '0, '0, 16'd50, 16'd150);      // overlap
      send_request(CMD_LOAD, '0, '0, 16'd65534, 16'd65535);
      send_request(CMD_LOAD, '0, '0, 16'd100, 16'd400);
      send_request(CMD_LOAD, '0, '0, 16'd1000, 16'd1200);
   endtask

   task automatic test_allocate_modes();
      send_request(CMD_ALLOC, 7'd1, 16'd0, '0, '0);         // zero size
      send_request(CMD_ALLOC, 7'd1, 16'd65535, '0, '0);     // nothing fits
      write_fit_mode(FIT_BEST);
      send_request(CMD_ALLOC, 7'd99, 16'd150, '0, '0);
      write_fit_mode(FIT_WORST);
      send_request(CMD_ALLOC, 7'd2, 16'd10, '0, '0);
      send_request(CMD_ALLOC, 7'd3, 16'd1, '0, '0);         // worst fit picks the largest hole
      write_fit_mode(FIT_SPARE);
      send_request(CMD_ALLOC, 7'd4, 16'd20, '0, '0);
      write_fit_mode(FIT_FIRST);
   endtask

   task automatic test_release();
      send_request(CMD_RELEASE, 7'd77, '0, '0, '0);         // unknown owner
      send_request(CMD_RELEASE, 7'd99, '0, '0, '0);
      send_request(CMD_RELEASE, 7'd2, '0, '0, '0);
      send_request(CMD_COALESCE, '0, '0, '0, '0);
   endtask

   // fill with touching two-unit holes, then coalesce them back into one
   task automatic test_table_full();
      int k;
      k = 0;
      drain_responses();
      while (shadow_count < SLOTS) begin
         send_request(CMD_LOAD, '0, '0, 16'(60000 + 2 * k), 16'(60002 + 2 * k));
         k++;
      end
      send_request(CMD_LOAD, '0, '0, 16'd50000, 16'd50010); // table full
      send_request(CMD_ALLOC, 7'd9, 16'd1, '0, '0);         // split with full table
      send_request(CMD_COALESCE, '0, '0, '0, '0);
   endtask

   task automatic test_random_traffic(input int count);
      int pick;
      logic [6:0] pid;
      logic [15:0] ps;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         pid = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 99))
                                           : 7'($urandom_range(0, 15));
         if (pick < 25) begin
            ps = 16'($urandom);
            send_request(CMD_LOAD, 7'($urandom), 16'($urandom), ps,
                         ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'(ps + $urandom_range(1, 3000)));
         end else if (pick < 62) begin
            send_request(CMD_ALLOC, pid,
                         ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2000)),
                         16'($urandom), 16'($urandom));
         end else if (pick < 87) begin
            // mostly release an owner that holds something
            for (int i = 0; i < shadow_count; i++)
               if (!shadow_hole[i] && $urandom_range(0, 2) == 0) pid = shadow_owner[i];
            send_request(CMD_RELEASE, pid, 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            send_request(CMD_COALESCE, 7'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_load_checks();
      test_allocate_modes();
      test_release();
      test_table_full();
      test_random_traffic(180);
      write_fit_mode(FIT_BEST);
      test_random_traffic(180);
      write_fit_mode(FIT_WORST);
      test_random_traffic(180);
      write_fit_mode(FIT_SPARE);
      test_random_traffic(180);
      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
design/vpa_pkg.sv
design/vpa_seg_mem.sv
design/vpa_fit_unit.sv
design/variable_partition_allocator_top.sv
verif/variable_partition_allocator_top_tb.sv
